// File: hdl/assert_macros.svh
// Assertion macros for the complex arithmetic unit checker.
// Both expect clk and arst_n in the scope where they are used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset
`define CAU_CHECK(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("cau check failed");

// Expression must never be true outside reset
`define CAU_NEVER(lbl, expr) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) \
		else $error("cau forbidden condition");

`endif

// File: hdl/cau_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cau_pkg
// Types, constants and helpers shared by the complex arithmetic unit.
// ----------------------------------------------------------------------------
package cau_pkg;

	// operation codes
	typedef enum logic [2:0] {
		KIND_ADD = 3'd0,
		KIND_SUB = 3'd1,
		KIND_MUL = 3'd2,
		KIND_DIV = 3'd3,
		KIND_MOD = 3'd4
	} kind_t;

	// cells in the divide / root chains (33 quotient or root bits)
	localparam int CELLS   = 33;
	// front stages (3) + chain + output register
	localparam int LATENCY = CELLS + 4;

	// one divide lane: partial remainder, unused dividend bits, quotient so far
	typedef struct packed {
		logic [63:0] r;
		logic [32:0] x;
		logic [32:0] q;
	} div_lane_t;

	// both divide lanes share one divisor
	typedef struct packed {
		logic [63:0] d;
		div_lane_t   lre;
		div_lane_t   lim;
	} div_t;

	// square root state: remaining radicand pairs, remainder, root so far
	typedef struct packed {
		logic [65:0] rad;
		logic [34:0] rem;
		logic [32:0] root;
	} sqrt_t;

	typedef struct packed {
		logic        neg;
		logic [63:0] mag;
	} smag_t;

	typedef struct packed {
		logic        ovf;
		logic [31:0] val;
	} sat_t;

	// side data that travels alongside the chains
	typedef struct packed {
		logic        valid;
		logic [2:0]  kind;
		logic [31:0] re;
		logic [31:0] im;
		logic        ovf;
		logic        dz;
		logic        neg_re;
		logic        neg_im;
		logic        cap_re;
		logic        cap_im;
	} meta_t;

	// sign and magnitude of a 65-bit sum lying in (-2^63, 2^63]
	function automatic smag_t to_smag(input logic signed [64:0] s);
		smag_t       o;
		logic [64:0] n;
		n     = 65'(0) - s;
		o.neg = s[64];
		o.mag = s[64] ? n[63:0] : s[63:0];
		return o;
	endfunction

	// saturate sign and magnitude into a signed 32-bit pattern
	function automatic sat_t sat32(input logic neg, input logic [64:0] mag);
		sat_t        o;
		logic [64:0] n;
		n = 65'(0) - mag;
		if (!neg) begin
			o.ovf = mag > 65'h0_7FFF_FFFF;
			o.val = o.ovf ? 32'h7FFF_FFFF : mag[31:0];
		end else begin
			o.ovf = mag > 65'h0_8000_0000;
			o.val = o.ovf ? 32'h8000_0000 : n[31:0];
		end
		return o;
	endfunction

endpackage

// File: hdl/cau_div_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cau_div_cell
// One restoring-division step for both quotient lanes, registered.
// ----------------------------------------------------------------------------
module cau_div_cell (
	input  logic           clk,
	input  cau_pkg::div_t  din,
	output cau_pkg::div_t  dout
);

	function automatic cau_pkg::div_lane_t step(input cau_pkg::div_lane_t l,
			input logic [63:0] d);
		cau_pkg::div_lane_t o;
		logic [64:0]        t;
		logic [64:0]        diff;
		logic               ge;
		t    = {l.r, l.x[32]};
		diff = t - {1'b0, d};
		ge   = t >= {1'b0, d};
		o.r  = ge ? diff[63:0] : t[63:0];
		o.x  = {l.x[31:0], 1'b0};
		o.q  = {l.q[31:0], ge};
		return o;
	endfunction

	// shift in next dividend bit, trial subtract, record quotient bit
	always_ff @(posedge clk) begin
		dout.d   <= din.d;
		dout.lre <= step(din.lre, din.d);
		dout.lim <= step(din.lim, din.d);
	end

endmodule

// File: hdl/cau_sqrt_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cau_sqrt_cell
// One digit-by-digit integer square root step, registered.
// ----------------------------------------------------------------------------
module cau_sqrt_cell (
	input  logic           clk,
	input  cau_pkg::sqrt_t din,
	output cau_pkg::sqrt_t dout
);

	logic [36:0] remt;
	logic [36:0] trial;
	logic [36:0] diff;
	logic        ge;

	// bring down next bit pair, test (root << 2) | 1
	always_comb begin
		remt  = {din.rem, din.rad[65:64]};
		trial = {2'b00, din.root, 2'b01};
		diff  = remt - trial;
		ge    = remt >= trial;
	end

	always_ff @(posedge clk) begin
		dout.rad  <= {din.rad[63:0], 2'b00};
		dout.rem  <= ge ? diff[34:0] : remt[34:0];
		dout.root <= {din.root[31:0], ge};
	end

endmodule

// File: hdl/complex_arithmetic_unit.sv
`timescale 1ns / 1ps
// Throughput: one operation per cycle; busy is held low, results leave in order.
// Depth is set by the 33-cell restoring divide and square root chains.
// Reset (arst_n low) clears all pipeline valid bits; items in flight are dropped.
// ----------------------------------------------------------------------------
// complex_arithmetic_unit
// Pipelined complex ALU on Q-format operands: add, subtract, multiply,
// divide and modulus, with saturation and divide-by-zero flag.
// ----------------------------------------------------------------------------
module complex_arithmetic_unit #(
	parameter int FRAC_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [2:0]         kind,
	input  logic signed [31:0] a_re,
	input  logic signed [31:0] a_im,
	input  logic signed [31:0] b_re,
	input  logic signed [31:0] b_im,
	output logic               done,
	output logic signed [31:0] res_re,
	output logic signed [31:0] res_im,
	output logic               div_zero,
	output logic               overflow
);

	localparam int NC = cau_pkg::CELLS;

	assign busy = 1'b0;

	// ---------------- stage 1: products, add / subtract ----------------
	logic               vld_s1;
	logic [2:0]         kind_s1;
	logic signed [63:0] p_rr_s1, p_ii_s1, p_ri_s1, p_ir_s1;
	logic signed [63:0] sq_ar_s1, sq_ai_s1, sq_br_s1, sq_bi_s1;
	logic [31:0]        as_re_s1, as_im_s1;
	logic               as_ovf_s1, bz_s1;

	logic signed [32:0] sum_re, sum_im;
	logic               sub_op;

	always_comb begin
		sub_op = kind == cau_pkg::KIND_SUB;
		sum_re = sub_op ? 33'(a_re) - 33'(b_re) : 33'(a_re) + 33'(b_re);
		sum_im = sub_op ? 33'(a_im) - 33'(b_im) : 33'(a_im) + 33'(b_im);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		kind_s1   <= kind;
		p_rr_s1   <= a_re * b_re;
		p_ii_s1   <= a_im * b_im;
		p_ri_s1   <= a_re * b_im;
		p_ir_s1   <= a_im * b_re;
		sq_ar_s1  <= a_re * a_re;
		sq_ai_s1  <= a_im * a_im;
		sq_br_s1  <= b_re * b_re;
		sq_bi_s1  <= b_im * b_im;
		as_re_s1  <= (sum_re[32] != sum_re[31]) ?
			(sum_re[32] ? 32'h8000_0000 : 32'h7FFF_FFFF) : sum_re[31:0];
		as_im_s1  <= (sum_im[32] != sum_im[31]) ?
			(sum_im[32] ? 32'h8000_0000 : 32'h7FFF_FFFF) : sum_im[31:0];
		as_ovf_s1 <= (sum_re[32] != sum_re[31]) || (sum_im[32] != sum_im[31]);
		bz_s1     <= (b_re == 32'sd0) && (b_im == 32'sd0);
	end

	// ---------------- stage 2: sums of products as sign / magnitude ----------------
	logic                 vld_s2;
	logic [2:0]           kind_s2;
	logic [31:0]          as_re_s2, as_im_s2;
	logic                 as_ovf_s2, bz_s2;
	cau_pkg::smag_t       mre_s2, mim_s2, dre_s2, dim_s2;
	logic [63:0]          d_s2, rad_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		kind_s2   <= kind_s1;
		as_re_s2  <= as_re_s1;
		as_im_s2  <= as_im_s1;
		as_ovf_s2 <= as_ovf_s1;
		bz_s2     <= bz_s1;
		mre_s2    <= cau_pkg::to_smag(65'(p_rr_s1) - 65'(p_ii_s1));
		mim_s2    <= cau_pkg::to_smag(65'(p_ri_s1) + 65'(p_ir_s1));
		dre_s2    <= cau_pkg::to_smag(65'(p_rr_s1) + 65'(p_ii_s1));
		dim_s2    <= cau_pkg::to_smag(65'(p_ir_s1) - 65'(p_ri_s1));
		d_s2      <= 64'(sq_br_s1) + 64'(sq_bi_s1);
		rad_s2    <= 64'(sq_ar_s1) + 64'(sq_ai_s1);
	end

	// ---------------- stage 3: product rounding, chain entry ----------------
	logic [64:0]          rnd_re, rnd_im;
	cau_pkg::sat_t        mul_re, mul_im;
	logic [63+FRAC_BITS:0] xw_re, xw_im;
	logic [63:0]          r0_re, r0_im;

	always_comb begin
		rnd_re = ({1'b0, mre_s2.mag} + (65'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
		rnd_im = ({1'b0, mim_s2.mag} + (65'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
		mul_re = cau_pkg::sat32(mre_s2.neg, rnd_re);
		mul_im = cau_pkg::sat32(mim_s2.neg, rnd_im);
		xw_re  = {dre_s2.mag, {FRAC_BITS{1'b0}}};
		xw_im  = {dim_s2.mag, {FRAC_BITS{1'b0}}};
		r0_re  = 64'(xw_re[63+FRAC_BITS:NC]);
		r0_im  = 64'(xw_im[63+FRAC_BITS:NC]);
	end

	cau_pkg::meta_t meta_s3;
	cau_pkg::div_t  div_s3;
	cau_pkg::sqrt_t sqrt_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			meta_s3 <= '0;
		end else begin
			meta_s3.valid  <= vld_s2;
			meta_s3.kind   <= kind_s2;
			meta_s3.dz     <= bz_s2 && (kind_s2 == cau_pkg::KIND_DIV);
			meta_s3.neg_re <= dre_s2.neg;
			meta_s3.neg_im <= dim_s2.neg;
			meta_s3.cap_re <= r0_re >= d_s2;
			meta_s3.cap_im <= r0_im >= d_s2;
			case (cau_pkg::kind_t'(kind_s2))
				cau_pkg::KIND_ADD, cau_pkg::KIND_SUB: begin
					meta_s3.re  <= as_re_s2;
					meta_s3.im  <= as_im_s2;
					meta_s3.ovf <= as_ovf_s2;
				end
				cau_pkg::KIND_MUL: begin
					meta_s3.re  <= mul_re.val;
					meta_s3.im  <= mul_im.val;
					meta_s3.ovf <= mul_re.ovf || mul_im.ovf;
				end
				default: begin
					meta_s3.re  <= '0;
					meta_s3.im  <= '0;
					meta_s3.ovf <= 1'b0;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		div_s3.d       <= d_s2;
		div_s3.lre.r   <= r0_re;
		div_s3.lre.x   <= xw_re[NC-1:0];
		div_s3.lre.q   <= '0;
		div_s3.lim.r   <= r0_im;
		div_s3.lim.x   <= xw_im[NC-1:0];
		div_s3.lim.q   <= '0;
		sqrt_s3.rad    <= {2'b00, rad_s2};
		sqrt_s3.rem    <= '0;
		sqrt_s3.root   <= '0;
	end

	// ---------------- chain of divide and root cells ----------------
	cau_pkg::div_t  div_c  [NC+1];
	cau_pkg::sqrt_t sqrt_c [NC+1];
	cau_pkg::meta_t meta_q [NC+1];

	assign div_c[0]  = div_s3;
	assign sqrt_c[0] = sqrt_s3;
	assign meta_q[0] = meta_s3;

	for (genvar c = 0; c < NC; c++) begin : g_cell
		cau_div_cell u_div (
			.clk  (clk),
			.din  (div_c[c]),
			.dout (div_c[c+1])
		);
		cau_sqrt_cell u_sqrt (
			.clk  (clk),
			.din  (sqrt_c[c]),
			.dout (sqrt_c[c+1])
		);
		// side data keeps step with the cells
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				meta_q[c+1] <= '0;
			end else begin
				meta_q[c+1] <= meta_q[c];
			end
		end
	end

	// ---------------- output register ----------------
	cau_pkg::meta_t m_end;
	cau_pkg::sat_t  q_re, q_im, root_sat;

	always_comb begin
		m_end    = meta_q[NC];
		q_re     = cau_pkg::sat32(m_end.neg_re,
			m_end.cap_re ? (65'(1) << NC) : 65'(div_c[NC].lre.q));
		q_im     = cau_pkg::sat32(m_end.neg_im,
			m_end.cap_im ? (65'(1) << NC) : 65'(div_c[NC].lim.q));
		root_sat = cau_pkg::sat32(1'b0, 65'(sqrt_c[NC].root));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= m_end.valid;
		end
	end

	// flags are only raised alongside a result beat
	always_ff @(posedge clk) begin
		div_zero <= m_end.valid && m_end.dz;
		case (cau_pkg::kind_t'(m_end.kind))
			cau_pkg::KIND_DIV: begin
				res_re   <= m_end.dz ? 32'sd0 : q_re.val;
				res_im   <= m_end.dz ? 32'sd0 : q_im.val;
				overflow <= m_end.valid && !m_end.dz && (q_re.ovf || q_im.ovf);
			end
			cau_pkg::KIND_MOD: begin
				res_re   <= root_sat.val;
				res_im   <= 32'sd0;
				overflow <= m_end.valid && root_sat.ovf;
			end
			default: begin
				res_re   <= m_end.re;
				res_im   <= m_end.im;
				overflow <= m_end.valid && m_end.ovf;
			end
		endcase
	end

endmodule

// File: hdl/cau_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cau_checker
// Port-level checks on the complex arithmetic unit, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module cau_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               start,
	input logic               busy,
	input logic               done,
	input logic signed [31:0] res_re,
	input logic signed [31:0] res_im,
	input logic               div_zero,
	input logic               overflow
);

	// fully pipelined: never refuses a beat
	`CAU_NEVER(a_never_busy, busy)

	// every result beat stems from a start a fixed latency earlier
	`CAU_CHECK(a_done_latency, done |-> $past(start, cau_pkg::LATENCY))

	// zero divisor gives a clean zero result without overflow
	`CAU_CHECK(a_div_zero_clean, div_zero |-> (done && !overflow && res_re == '0 && res_im == '0))

	// flags only travel with a result beat
	`CAU_CHECK(a_ovf_with_done, overflow |-> done)

endmodule

bind complex_arithmetic_unit cau_checker u_cau_checker (.*);
